>>> src/parent_candidate_table_select_top_macros.svh
// Assertion macros shared by the parent candidate table select block.
`ifndef PARENT_CANDIDATE_TABLE_SELECT_TOP_MACROS_SVH
`define PARENT_CANDIDATE_TABLE_SELECT_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PCTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Invariant checked on every clock edge outside reset.
`define PCTS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    `PCTS_ASSERT_IMPL(lbl, clk, rst_n, 1'b1, cond, msg)

`endif

>>> src/pcts_pkg.sv
// Package: types, constants and codes of the parent candidate table select block.
`timescale 1ns / 1ps

package pcts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [7:0]  INITIAL_RANK = 8'd100;
    localparam logic [7:0]  RANK_MAX     = 8'd255;
    localparam logic [15:0] NULL_ADDR    = 16'd0;

    typedef enum logic [1:0] {
        ST_RECORDED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_CHOSEN   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        OP_BEACON = 1'b0,
        OP_CHOOSE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESP
    } t_state;

    // One table entry as read from the candidate memory.
    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  rank;
        logic [15:0] sig;
    } t_entry;

    // Sequencer request to the candidate memory.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic             wr_new;
        logic [IDX_W-1:0] wr_idx;
        logic [15:0]      wr_addr;
        logic [7:0]       wr_rank;
        logic [15:0]      wr_sig;
    } t_tbl_req;

    // Result of the shared compare unit.
    typedef struct packed {
        logic match;
        logic better;
    } t_cmp_res;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } t_seq_stat;

endpackage

>>> src/pcts_table.sv
// Candidate memory: address, rank and signal per entry, one write and one registered read port.
`timescale 1ns / 1ps

module pcts_table import pcts_pkg::*; (
    input  logic     i_clk,
    input  t_tbl_req i_req,
    output t_entry   o_rd
);

    logic [15:0] r_mem_addr [TABLE_DEPTH];
    logic [7:0]  r_mem_rank [TABLE_DEPTH];
    logic [15:0] r_mem_sig  [TABLE_DEPTH];
    t_entry      r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem_sig[i_req.wr_idx] <= i_req.wr_sig;
            // addr and rank are only set when the entry is first taken
            if (i_req.wr_new) begin
                r_mem_addr[i_req.wr_idx] <= i_req.wr_addr;
                r_mem_rank[i_req.wr_idx] <= i_req.wr_rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd.addr <= r_mem_addr[i_req.rd_idx];
            r_rd.rank <= r_mem_rank[i_req.rd_idx];
            r_rd.sig  <= r_mem_sig[i_req.rd_idx];
        end
    end

    assign o_rd = r_rd;

endmodule

>>> src/pcts_cmp.sv
// Shared compare unit: address match and best-parent ordering of one entry.
`timescale 1ns / 1ps

module pcts_cmp import pcts_pkg::*; (
    input  t_entry      i_entry,
    input  t_entry      i_best,
    input  logic        i_have_best,
    input  logic [15:0] i_key_addr,
    output t_cmp_res    o_res
);

    always_comb begin
        o_res.match  = (i_entry.addr == i_key_addr);
        // lower rank wins, then higher signal; a full tie keeps the earlier entry
        o_res.better = !i_have_best
                    || (i_entry.rank < i_best.rank)
                    || ((i_entry.rank == i_best.rank) && (i_entry.sig > i_best.sig));
    end

endmodule

>>> src/pcts_seq.sv
// Sequencer: scans the table one entry per cycle, updates node state, holds the result register.
`timescale 1ns / 1ps

module pcts_seq import pcts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [15:0] i_sender_addr,
    input  logic [7:0]  i_sender_rank,
    input  logic [15:0] i_signal_strength,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_parent_addr,
    output logic [7:0]  o_own_rank,
    output t_tbl_req    o_tbl_req,
    input  t_entry      i_tbl_rd,
    output t_seq_stat   o_stat
);

    t_state           r_state, n_state;
    t_op              r_op;
    logic [15:0]      r_key_addr;
    logic [7:0]       r_key_rank;
    logic [15:0]      r_key_sig;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_new;
    t_status          r_status;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_node_rank;
    logic [15:0]      r_parent;
    logic             r_have;
    t_entry           r_best;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [15:0]      r_out_parent;
    logic [7:0]       r_out_rank;

    t_cmp_res         w_cmp;
    logic             w_eval, w_last, w_hit, w_take, w_full, w_final_have, w_out_free;
    t_entry           w_final_best;
    logic [CNT_W-1:0] w_prev_idx;
    logic [8:0]       w_rank_inc;
    logic [7:0]       w_rank_sat;

    pcts_cmp u_cmp (
        .i_entry     (i_tbl_rd),
        .i_best      (r_best),
        .i_have_best (r_have),
        .i_key_addr  (r_key_addr),
        .o_res       (w_cmp)
    );

    // r_idx is the next read address; the entry at r_idx-1 is on the read port
    always_comb begin
        w_eval       = (r_idx != '0);
        w_last       = (r_idx == r_count);
        w_hit        = w_eval && (r_op == OP_BEACON) && w_cmp.match;
        w_take       = w_eval && (r_op == OP_CHOOSE) && w_cmp.better;
        w_full       = (r_count == CNT_W'(TABLE_DEPTH));
        w_final_best = w_take ? i_tbl_rd : r_best;
        w_final_have = r_have || w_take;
        w_prev_idx   = r_idx - 1'b1;
        w_out_free   = !r_out_valid || !i_out_stall;
        w_rank_inc   = {1'b0, w_final_best.rank} + 9'd1;
        w_rank_sat   = w_rank_inc[8] ? RANK_MAX : w_rank_inc[7:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_WRITE;
                end else if (w_last) begin
                    if (r_op == OP_BEACON && !w_full) n_state = S_WRITE;
                    else                              n_state = S_RESP;
                end
            end
            S_WRITE: n_state = S_RESP;
            S_RESP: begin
                if (w_out_free) n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall        = (r_state != S_IDLE);
        o_tbl_req         = '0;
        o_tbl_req.rd_idx  = r_idx[IDX_W-1:0];
        o_tbl_req.wr_idx  = r_hit_idx;
        o_tbl_req.wr_new  = r_new;
        o_tbl_req.wr_addr = r_key_addr;
        o_tbl_req.wr_rank = r_key_rank;
        o_tbl_req.wr_sig  = r_key_sig;
        unique case (r_state)
            S_IDLE:  ;
            S_SCAN:  o_tbl_req.rd_en = !w_last;
            S_WRITE: o_tbl_req.wr_en = 1'b1;
            S_RESP:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_node_rank <= INITIAL_RANK;
            r_parent    <= NULL_ADDR;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // the result cycle reloads the register itself
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= t_op'(i_operation);
                        r_key_addr <= i_sender_addr;
                        r_key_rank <= i_sender_rank;
                        r_key_sig  <= i_signal_strength;
                        r_idx      <= '0;
                        r_have     <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (w_take) begin
                        r_best <= i_tbl_rd;
                        r_have <= 1'b1;
                    end
                    if (w_hit) begin
                        r_hit_idx <= w_prev_idx[IDX_W-1:0];
                        r_new     <= 1'b0;
                        r_status  <= ST_RECORDED;
                    end else if (w_last) begin
                        if (r_op == OP_BEACON) begin
                            if (w_full) begin
                                r_status <= ST_DROPPED;
                            end else begin
                                // entries are never freed: the next free one is at r_count
                                r_hit_idx <= r_count[IDX_W-1:0];
                                r_new     <= 1'b1;
                                r_count   <= r_count + 1'b1;
                                r_status  <= ST_RECORDED;
                            end
                        end else if (w_final_have) begin
                            r_parent    <= w_final_best.addr;
                            r_node_rank <= w_rank_sat;
                            r_status    <= ST_CHOSEN;
                        end else begin
                            r_status <= ST_EMPTY;
                        end
                    end
                end
                S_WRITE: ;
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_parent <= r_parent;
                        r_out_rank   <= r_node_rank;
                    end
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_parent_addr = r_out_parent;
    assign o_own_rank    = r_out_rank;
    assign o_stat.count  = r_count;
    assign o_stat.busy   = (r_state != S_IDLE);

endmodule

>>> src/parent_candidate_table_select_top.sv
// Top level of the parent candidate table select block.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-----------------------------------------------------
//  in      | i_in_valid  | o_in_stall   | i_operation, i_sender_addr, i_sender_rank,
//          |             |              | i_signal_strength
//  out     | o_out_valid | i_out_stall  | o_status, o_parent_addr, o_own_rank
//
// Flow: an accepted item is scanned over the N occupied entries, then a beacon that writes its
// entry passes the write state, while a choose or a dropped beacon goes straight to the result
// state; the next item is taken in the idle state after it. The scan reads one entry per
// cycle through the candidate memory's single registered read port. A beacon whose address
// hits stops its scan at that entry.
// Reset (synchronous, active low) empties the table, sets own rank 100 and parent 0;
// no clearing pass, entries at or above the fill count are never read.
// A stalled result waits in the output register; the next item is accepted meanwhile,
// and its own result waits for the register to free up.
`timescale 1ns / 1ps
`include "parent_candidate_table_select_top_macros.svh"

module parent_candidate_table_select_top import pcts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [15:0] i_sender_addr,
    input  logic [7:0]  i_sender_rank,
    input  logic [15:0] i_signal_strength,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_parent_addr,
    output logic [7:0]  o_own_rank
);

    t_tbl_req  w_tbl_req;
    t_entry    w_tbl_rd;
    t_seq_stat w_stat;

    // candidate memory: address, rank, signal of each neighbor
    pcts_table u_table (
        .i_clk (i_clk),
        .i_req (w_tbl_req),
        .o_rd  (w_tbl_rd)
    );

    // sequencer with the shared compare unit and the result register
    pcts_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_sender_addr     (i_sender_addr),
        .i_sender_rank     (i_sender_rank),
        .i_signal_strength (i_signal_strength),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_parent_addr     (o_parent_addr),
        .o_own_rank        (o_own_rank),
        .o_tbl_req         (w_tbl_req),
        .i_tbl_rd          (w_tbl_rd),
        .o_stat            (w_stat)
    );

    // writes only touch occupied entries (a new entry is counted before its write)
    `PCTS_ASSERT_IMPL(a_wr_in_range, i_clk, i_rst_n, w_tbl_req.wr_en, CNT_W'(w_tbl_req.wr_idx) < w_stat.count, "table write beyond fill count")
    `PCTS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, w_stat.count <= CNT_W'(TABLE_DEPTH), "fill count above table depth")
    `PCTS_ASSERT_IMPL(a_count_step, i_clk, i_rst_n, w_stat.count != $past(w_stat.count), w_stat.count == CNT_W'($past(w_stat.count) + 1'b1), "fill count moved by other than one")
    `PCTS_ASSERT_IMPL(a_result_after_work, i_clk, i_rst_n, $rose(o_out_valid), $past(w_stat.busy), "result appeared without an item in work")

endmodule
